### rtl/v3a_pkg.sv
// v3a_pkg: shared widths, opcodes, word types and saturation helper
// for the three-component vector unit; no dependencies
package v3a_pkg;

    // word and fixed-point format
    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OP_W       = 4;
    localparam int LANES      = 3;

    // derived arithmetic widths
    localparam int PROD_W     = 2 * WORD_W;
    localparam int FMUL_W     = PROD_W - FRAC_BITS;
    localparam int DIVD_W     = WORD_W + FRAC_BITS;
    localparam int ROOT_W     = WORD_W;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 4;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = DIVD_W;

    // saturation limits, wide and word sized
    localparam logic signed [PROD_W-1:0] SAT_HI =
        {{(PROD_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [WORD_W-1:0] WORD_HI = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_LO = {1'b1, {(WORD_W-1){1'b0}}};

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_SADD  = 4'd4;
    localparam logic [OP_W-1:0] OP_SSUB  = 4'd5;
    localparam logic [OP_W-1:0] OP_SMUL  = 4'd6;
    localparam logic [OP_W-1:0] OP_SDIV  = 4'd7;
    localparam logic [OP_W-1:0] OP_DOT   = 4'd8;
    localparam logic [OP_W-1:0] OP_CROSS = 4'd9;
    localparam logic [OP_W-1:0] OP_SQMAG = 4'd10;
    localparam logic [OP_W-1:0] OP_MAG   = 4'd11;
    localparam logic [OP_W-1:0] OP_NORM  = 4'd12;
    localparam logic [OP_W-1:0] OP_EQ    = 4'd13;

    typedef logic signed [WORD_W-1:0] t_word;

    // input and output words
    typedef struct packed {
        logic [OP_W-1:0] op;
        t_word           a_x;
        t_word           a_y;
        t_word           a_z;
        t_word           b_x;
        t_word           b_y;
        t_word           b_z;
        t_word           scalar_in;
    } t_in;

    typedef struct packed {
        t_word r_x;
        t_word r_y;
        t_word r_z;
        t_word r_scalar;
        logic  is_equal;
        logic  div_zero;
        logic  overflowed;
    } t_out;

    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_sat;

    // divide operands of one lane, as magnitudes and signs
    typedef struct packed {
        logic              a_neg;
        logic              a_zero;
        logic [WORD_W-1:0] a_mag;
        logic              d_neg;
        logic [WORD_W-1:0] d_mag;
    } t_dop;

    // what a lane hands to the merge stage
    typedef struct packed {
        t_word                    vec;
        logic                     vec_ovf;
        logic signed [FMUL_W-1:0] fm;
        logic [RAD_W-1:0]         sq;
        logic                     eq;
        t_dop                     dop;
    } t_lane;

    // merged word waiting on the square root
    typedef struct packed {
        logic [OP_W-1:0]       op;
        t_word [LANES-1:0]     vec;
        t_word                 rs;
        logic                  eq;
        logic                  ovf;
        t_dop [LANES-1:0]      dop;
    } t_carry;

    // merged word waiting on the dividers
    typedef struct packed {
        logic [OP_W-1:0]   op;
        t_word [LANES-1:0] vec;
        t_word             rs;
        logic              eq;
        logic              ovf;
    } t_tail;

    typedef struct packed {
        t_word q;
        logic  ovf;
        logic  dz;
    } t_div_res;

    // clamp a wide signed value to the word range
    function automatic t_sat sat_word(input logic signed [PROD_W-1:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.val = WORD_HI;
            s.ovf = 1'b1;
        end else if (v < SAT_LO) begin
            s.val = WORD_LO;
            s.ovf = 1'b1;
        end else begin
            s.val = v[WORD_W-1:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/vector3_alu_unit.sv
// vector3_alu_unit: three-lane Q16.16 vector unit, top level
// throughput: one word per cycle unless the output stall holds the pipe
// the 32-stage root and 48-stage divider are pipelined
// a stalled output holds the pipe only once a word reaches its last stage
// reset (synchronous, active low) clears the valid bits; data registers are not reset
// depends on v3a_pkg, v3a_lane, v3a_sqrt, v3a_div
module vector3_alu_unit
    import v3a_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_word,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_word
);

    localparam int PIPE_LEN = 4 + SQ_STAGES + DIV_STAGES + 1;

    logic              r_vld [PIPE_LEN];
    logic              w_adv;
    logic              w_out_free;
    t_in               r_in;
    logic [OP_W-1:0]   r_op1;
    logic [OP_W-1:0]   r_op2;

    t_word             w_a [LANES];
    t_word             w_b [LANES];
    t_lane             w_lane [LANES];

    t_sat              w_dot;
    logic [RAD_W-1:0]  w_rad;
    t_carry            w_carry;
    t_carry            r_c3;
    logic [RAD_W-1:0]  r_rad;
    t_carry            r_cdl [SQ_STAGES];

    logic [ROOT_W-1:0] w_root;
    t_carry            w_cs;
    t_sat              w_mag;
    t_tail             w_tail;
    t_tail             r_tdl [DIV_STAGES+1];
    t_div_res          w_q [LANES];

    t_tail             w_tl;
    t_out              w_out;
    t_out              r_out;
    logic              r_out_vld;

    // pipe moves unless a finished word is blocked at the end
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_adv      = !r_vld[PIPE_LEN-1] || w_out_free;
    assign o_stall    = !w_adv;

    // valid bits along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LEN; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < PIPE_LEN; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_word;
        end
    end

    // op delayed to line up with lane stage two
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1 <= r_in.op;
            r_op2 <= r_op1;
        end
    end

    assign w_a[0] = r_in.a_x;
    assign w_a[1] = r_in.a_y;
    assign w_a[2] = r_in.a_z;
    assign w_b[0] = r_in.b_x;
    assign w_b[1] = r_in.b_y;
    assign w_b[2] = r_in.b_z;

    // component lanes, cross operands rotated per lane
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        v3a_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_op   (r_in.op),
            .i_a    (w_a[l]),
            .i_b    (w_b[l]),
            .i_s    (r_in.scalar_in),
            .i_c1a  (w_a[(l+1)%LANES]),
            .i_c1b  (w_b[(l+2)%LANES]),
            .i_c2a  (w_a[(l+2)%LANES]),
            .i_c2b  (w_b[(l+1)%LANES]),
            .o_lane (w_lane[l])
        );
    end

    // merge lanes: dot sum, radicand, equality, flags
    assign w_dot = sat_word(PROD_W'(w_lane[0].fm) + PROD_W'(w_lane[1].fm)
                            + PROD_W'(w_lane[2].fm));
    assign w_rad = w_lane[0].sq + w_lane[1].sq + w_lane[2].sq;

    always_comb begin
        w_carry.op  = r_op2;
        w_carry.rs  = '0;
        w_carry.eq  = (r_op2 == OP_EQ) && w_lane[0].eq && w_lane[1].eq
                      && w_lane[2].eq;
        w_carry.ovf = w_lane[0].vec_ovf | w_lane[1].vec_ovf | w_lane[2].vec_ovf;
        if (r_op2 == OP_DOT || r_op2 == OP_SQMAG) begin
            w_carry.rs  = w_dot.val;
            w_carry.ovf = w_carry.ovf | w_dot.ovf;
        end
        for (int l = 0; l < LANES; l++) begin
            w_carry.vec[l] = w_lane[l].vec;
            w_carry.dop[l] = w_lane[l].dop;
        end
    end

    // merge register ahead of the root
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c3  <= w_carry;
            r_rad <= w_rad;
        end
    end

    // square root of the squared magnitude
    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // carry the merged word alongside the root
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cdl[0] <= r_c3;
            for (int i = 1; i < SQ_STAGES; i++) begin
                r_cdl[i] <= r_cdl[i-1];
            end
        end
    end

    assign w_cs  = r_cdl[SQ_STAGES-1];
    assign w_mag = sat_word(PROD_W'({1'b0, w_root}));

    // magnitude result joins the word here
    always_comb begin
        w_tail.op  = w_cs.op;
        w_tail.vec = w_cs.vec;
        w_tail.eq  = w_cs.eq;
        w_tail.rs  = w_cs.rs;
        w_tail.ovf = w_cs.ovf;
        if (w_cs.op == OP_MAG) begin
            w_tail.rs  = w_mag.val;
            w_tail.ovf = w_cs.ovf | w_mag.ovf;
        end
    end

    // divider lanes, normalise divides by the root
    for (genvar l = 0; l < LANES; l++) begin : g_div
        t_dop w_dop;

        always_comb begin
            w_dop = w_cs.dop[l];
            if (w_cs.op == OP_NORM) begin
                w_dop.d_neg = 1'b0;
                w_dop.d_mag = w_root;
            end
        end

        v3a_div u_div (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_dop (w_dop),
            .o_res (w_q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdl[0] <= w_tail;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                r_tdl[i] <= r_tdl[i-1];
            end
        end
    end

    // final merge of divider results
    assign w_tl = r_tdl[DIV_STAGES];

    always_comb begin
        w_out.r_x        = w_tl.vec[0];
        w_out.r_y        = w_tl.vec[1];
        w_out.r_z        = w_tl.vec[2];
        w_out.r_scalar   = w_tl.rs;
        w_out.is_equal   = w_tl.eq;
        w_out.div_zero   = 1'b0;
        w_out.overflowed = w_tl.ovf;
        if (w_tl.op == OP_DIV || w_tl.op == OP_SDIV || w_tl.op == OP_NORM) begin
            w_out.r_x        = w_q[0].q;
            w_out.r_y        = w_q[1].q;
            w_out.r_z        = w_q[2].q;
            w_out.div_zero   = w_q[0].dz | w_q[1].dz | w_q[2].dz;
            w_out.overflowed = w_tl.ovf | w_q[0].ovf | w_q[1].ovf | w_q[2].ovf;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_vld[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_vld[PIPE_LEN-1]) begin
            r_out <= w_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

`ifndef NO_ASSERTIONS
    // an equality word carries nothing else
    a_eq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.is_equal |-> o_word.r_x == '0 && o_word.r_y == '0
            && o_word.r_z == '0 && o_word.r_scalar == '0
            && !o_word.div_zero && !o_word.overflowed)
        else $error("equality word with other fields set");

    // divide by zero only comes from vector divides
    a_dz_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.div_zero |-> o_word.r_scalar == '0 && !o_word.is_equal)
        else $error("divide by zero flag on a scalar result");

    // an accepted word enters the pipe
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted word lost at pipe entry");

    // a word blocked at the pipe end stays there
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_LEN-1] && o_stall |=> r_vld[PIPE_LEN-1])
        else $error("blocked word dropped at pipe end");
`endif

endmodule

### rtl/v3a_lane.sv
// v3a_lane: one component lane, multipliers, add/sub and saturation
// over two register stages; depends on v3a_pkg
module v3a_lane
    import v3a_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_adv,
    input  logic [OP_W-1:0] i_op,
    input  t_word           i_a,
    input  t_word           i_b,
    input  t_word           i_s,
    input  t_word           i_c1a,
    input  t_word           i_c1b,
    input  t_word           i_c2a,
    input  t_word           i_c2b,
    output t_lane           o_lane
);

    t_word                    w_x;
    t_word                    w_y;
    logic signed [WORD_W:0]   w_addsub;

    logic [OP_W-1:0]          r_op;
    logic signed [PROD_W-1:0] r_prod1;
    logic signed [PROD_W-1:0] r_prod2;
    logic signed [WORD_W:0]   r_addsub;
    logic                     r_eq;
    t_word                    r_a;
    t_word                    r_d;

    logic signed [FMUL_W-1:0] w_f1;
    logic signed [FMUL_W-1:0] w_f2;
    logic signed [FMUL_W:0]   w_diff;
    t_sat                     w_vs;

    t_lane                    r_lane;

    // first multiplier operands
    always_comb begin
        w_x = i_a;
        w_y = i_b;
        case (i_op)
            OP_SMUL: w_y = i_s;
            OP_SQMAG, OP_MAG, OP_NORM: w_y = i_a;
            OP_CROSS: begin
                w_x = i_c1a;
                w_y = i_c1b;
            end
            default: w_y = i_b;
        endcase
    end

    // add and subtract, one bit wider
    always_comb begin
        case (i_op)
            OP_SUB:  w_addsub = {i_a[WORD_W-1], i_a} - {i_b[WORD_W-1], i_b};
            OP_SADD: w_addsub = {i_a[WORD_W-1], i_a} + {i_s[WORD_W-1], i_s};
            OP_SSUB: w_addsub = {i_a[WORD_W-1], i_a} - {i_s[WORD_W-1], i_s};
            default: w_addsub = {i_a[WORD_W-1], i_a} + {i_b[WORD_W-1], i_b};
        endcase
    end

    // stage one: products and sums
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op     <= i_op;
            r_prod1  <= PROD_W'(w_x) * PROD_W'(w_y);
            r_prod2  <= PROD_W'(i_c2a) * PROD_W'(i_c2b);
            r_addsub <= w_addsub;
            r_eq     <= (i_a == i_b);
            r_a      <= i_a;
            r_d      <= (i_op == OP_SDIV) ? i_s : i_b;
        end
    end

    // drop fraction bits, floor on two's complement
    assign w_f1   = FMUL_W'(r_prod1 >>> FRAC_BITS);
    assign w_f2   = FMUL_W'(r_prod2 >>> FRAC_BITS);
    assign w_diff = {w_f1[FMUL_W-1], w_f1} - {w_f2[FMUL_W-1], w_f2};

    // lane vector result
    always_comb begin
        case (r_op)
            OP_ADD, OP_SUB, OP_SADD, OP_SSUB: w_vs = sat_word(PROD_W'(r_addsub));
            OP_MUL, OP_SMUL:                  w_vs = sat_word(PROD_W'(w_f1));
            OP_CROSS:                         w_vs = sat_word(PROD_W'(w_diff));
            default:                          w_vs = '0;
        endcase
    end

    // stage two: results and divide operands
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane.vec        <= w_vs.val;
            r_lane.vec_ovf    <= w_vs.ovf;
            r_lane.fm         <= w_f1;
            r_lane.sq         <= r_prod1;
            r_lane.eq         <= r_eq;
            r_lane.dop.a_neg  <= r_a[WORD_W-1];
            r_lane.dop.a_zero <= (r_a == '0);
            r_lane.dop.a_mag  <= r_a[WORD_W-1] ? -r_a : r_a;
            r_lane.dop.d_neg  <= r_d[WORD_W-1];
            r_lane.dop.d_mag  <= r_d[WORD_W-1] ? -r_d : r_d;
        end
    end

    assign o_lane = r_lane;

endmodule

### rtl/v3a_sqrt.sv
// v3a_sqrt: pipelined integer square root, one root bit per stage
// depends on v3a_pkg
module v3a_sqrt
    import v3a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [REM_W-1:0]  r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0] r_root [SQ_STAGES];
    logic [RAD_W-1:0]  r_rad  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [RAD_W-1:0]  w_rad_in;
        logic [REM_W-1:0]  w_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign w_sh    = {w_rem_in[REM_W-3:0], w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = REM_W'({w_root_in, 2'b01});
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= w_ge ? (w_sh - w_trial) : w_sh;
                r_root[k] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_rad[k]  <= w_rad_in << 2;
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

### rtl/v3a_div.sv
// v3a_div: pipelined restoring divider for one lane, one quotient bit
// per stage, then sign, saturation and divide-by-zero; depends on v3a_pkg
module v3a_div
    import v3a_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_adv,
    input  t_dop     i_dop,
    output t_div_res o_res
);

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DIVD_W-1:0] w;
        logic [WORD_W-1:0] den;
        logic              q_neg;
        logic              dz;
        logic              n_neg;
        logic              n_zero;
    } t_dstep;

    t_dstep                 r_st [DIV_STAGES];
    t_dstep                 w_last;
    logic signed [DIVD_W:0] w_qs;
    t_sat                   w_sat;
    t_div_res               w_res;
    t_div_res               r_res;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        t_dstep          w_in;
        logic [WORD_W:0] w_sh;
        logic            w_ge;

        if (k == 0) begin : g_first
            always_comb begin
                w_in.rem    = '0;
                w_in.w      = {i_dop.a_mag, {FRAC_BITS{1'b0}}};
                w_in.den    = i_dop.d_mag;
                w_in.q_neg  = i_dop.a_neg ^ i_dop.d_neg;
                w_in.dz     = (i_dop.d_mag == '0);
                w_in.n_neg  = i_dop.a_neg;
                w_in.n_zero = i_dop.a_zero;
            end
        end else begin : g_next
            assign w_in = r_st[k-1];
        end

        // shift in next dividend bit and compare
        assign w_sh = {w_in.rem, w_in.w[DIVD_W-1]};
        assign w_ge = (w_sh >= {1'b0, w_in.den});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[k].rem    <= w_ge ? WORD_W'(w_sh - {1'b0, w_in.den})
                                       : w_sh[WORD_W-1:0];
                r_st[k].w      <= {w_in.w[DIVD_W-2:0], w_ge};
                r_st[k].den    <= w_in.den;
                r_st[k].q_neg  <= w_in.q_neg;
                r_st[k].dz     <= w_in.dz;
                r_st[k].n_neg  <= w_in.n_neg;
                r_st[k].n_zero <= w_in.n_zero;
            end
        end
    end

    // sign and saturate the quotient
    assign w_last = r_st[DIV_STAGES-1];
    assign w_qs   = w_last.q_neg ? -{1'b0, w_last.w} : {1'b0, w_last.w};
    assign w_sat  = sat_word(PROD_W'(w_qs));

    always_comb begin
        if (w_last.dz) begin
            w_res.q   = w_last.n_zero ? '0 : (w_last.n_neg ? WORD_LO : WORD_HI);
            w_res.ovf = 1'b0;
            w_res.dz  = 1'b1;
        end else begin
            w_res.q   = w_sat.val;
            w_res.ovf = w_sat.ovf;
            w_res.dz  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res = r_res;

endmodule
